/* rtl/core/ndps_pkg.sv */
package ndps_pkg;

    // Fixed-point format of activations, weights and results
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q14   = 16384;

    // Softsign quotient magnitude is always below one, so 14 bits suffice
    localparam int QUOT_BITS = 14;
    localparam int Q_W       = QUOT_BITS + 1;

    localparam int GAIN_W    = 16;
    localparam int RESULT_W  = 16;
    localparam int SCALE_W   = Q_W + GAIN_W;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd16384;

    // Configuration port geometry
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Entries in the queue between accumulator and activation unit
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        REG_GAIN         = 1'b0,
        REG_OUTPUT_LAYER = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SCALE,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain;
        logic                     output_layer;
    } cfg_t;

endpackage

/* rtl/core/ndps_if.sv */
interface ndps_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] activation;
    logic signed [DATA_WIDTH-1:0] weight;
    logic                         last;

    modport source (output valid, output activation, output weight, output last,
                    input ready);
    modport sink   (input valid, input activation, input weight, input last,
                    output ready);
endinterface

interface ndps_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ndps_pkg::RESULT_W-1:0]    result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

/* rtl/core/ndps_front.sv */
module ndps_front #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 40
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [DATA_WIDTH-1:0]             activation,
    input  logic signed [DATA_WIDTH-1:0]             weight,
    input  logic                                     last,
    output logic                                     push_valid,
    output logic [ACC_WIDTH-ndps_pkg::FRAC_BITS-1:0] push_data,
    input  logic                                     queue_full
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
    localparam int HI_W   = SUM_W - ACC_WIDTH + 1;

    logic                        prod_valid_reg;
    logic                        prod_last_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [ACC_WIDTH-1:0] acc_sat;
    logic [SUM_W-1:0]            sum;
    logic [HI_W-1:0]             sum_hi;
    logic                        advance;

    // Stall only when a finished sum cannot enter the queue
    assign advance  = !(prod_valid_reg && prod_last_reg && queue_full);
    assign in_ready = advance;

    // Product stage
    assign prod_next = activation * weight;

    // Saturating accumulate
    always_comb
    begin
        sum = {{(SUM_W-ACC_WIDTH){acc_reg[ACC_WIDTH-1]}}, acc_reg}
            + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        sum_hi = sum[SUM_W-1:ACC_WIDTH-1];
        if ((&sum_hi) || !(|sum_hi))
        begin
            acc_sat = sum[ACC_WIDTH-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            acc_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
    end

    // Clear after the last term, else keep the running sum
    always_comb
    begin
        acc_next = acc_reg;
        if (advance && prod_valid_reg)
        begin
            acc_next = prod_last_reg ? '0 : acc_sat;
        end
    end

    assign push_valid = advance && prod_valid_reg && prod_last_reg;
    assign push_data  = acc_sat[ACC_WIDTH-1:ndps_pkg::FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (advance)
            begin
                prod_valid_reg <= in_valid;
            end
        end
    end

    // Product payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg      <= prod_next;
            prod_last_reg <= last;
        end
    end

endmodule

/* rtl/core/ndps_fifo.sv */
module ndps_fifo #(
    parameter int WIDTH = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(ndps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ndps_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [ndps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(ndps_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store a request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/ndps_back.sv */
module ndps_back #(
    parameter int S_W = 26
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  logic [S_W-1:0]                       pop_data,
    input  ndps_pkg::cfg_t                       cfg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ndps_pkg::RESULT_W-1:0] result
);

    localparam int STEP_W = $clog2(ndps_pkg::QUOT_BITS);
    localparam int QB     = ndps_pkg::QUOT_BITS;

    ndps_pkg::back_state_t state_reg;
    ndps_pkg::back_state_t state_next;

    logic                                 neg_reg;
    logic [S_W:0]                         den_reg;
    logic [S_W+1:0]                       rem_reg;
    logic [QB-1:0]                        quo_reg;
    logic [STEP_W-1:0]                    step_reg;
    logic signed [ndps_pkg::Q_W-1:0]      q_reg;
    logic signed [ndps_pkg::SCALE_W-1:0]  scale_reg;
    logic                                 out_valid_reg;
    logic signed [ndps_pkg::RESULT_W-1:0] result_reg;

    logic [S_W-1:0]                       mag;
    logic [S_W+1:0]                       rem_shift;
    logic                                 rem_ge;
    logic signed [ndps_pkg::Q_W-1:0]      q_signed;
    logic                                 take;
    logic                                 load_out;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Magnitude of the incoming sum
    assign mag = pop_data[S_W-1] ? (~pop_data + S_W'(1)) : pop_data;

    // One restoring-division step
    assign rem_shift = {rem_reg[S_W:0], 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign q_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ndps_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ndps_pkg::BK_DIV;
                end
            end
            ndps_pkg::BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ndps_pkg::BK_SCALE;
                end
            end
            ndps_pkg::BK_SCALE:
            begin
                state_next = ndps_pkg::BK_DONE;
            end
            ndps_pkg::BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ndps_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ndps_pkg::BK_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop_ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ndps_pkg::BK_IDLE:  pop_ready = 1'b1;
            ndps_pkg::BK_DIV:   ;
            ndps_pkg::BK_SCALE: ;
            ndps_pkg::BK_DONE:  load_out = !out_valid_reg || out_ready;
            default:            ;
        endcase
    end

    assign take = pop_ready && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ndps_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider, scaling and output datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            neg_reg  <= pop_data[S_W-1];
            den_reg  <= {1'b0, mag} + (S_W+1)'(ndps_pkg::ONE_Q14);
            rem_reg  <= {2'b00, mag};
            quo_reg  <= '0;
            step_reg <= STEP_W'(QB - 1);
        end
        else if (state_reg == ndps_pkg::BK_DIV)
        begin
            rem_reg  <= rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quo_reg  <= {quo_reg[QB-2:0], rem_ge};
            step_reg <= step_reg - STEP_W'(1);
        end
        if (state_reg == ndps_pkg::BK_SCALE)
        begin
            q_reg     <= q_signed;
            scale_reg <= q_signed * cfg.gain;
        end
        if (load_out)
        begin
            if (cfg.output_layer)
            begin
                result_reg <= ndps_pkg::RESULT_W'(q_reg);
            end
            else
            begin
                result_reg <= scale_reg[ndps_pkg::FRAC_BITS +: ndps_pkg::RESULT_W];
            end
        end
    end

endmodule

/* rtl/core/neuron_dot_product_softsign_unit.sv */
// Path: last product registered, sum queued, divided, scaled, result registered.
// Throughput: one term per cycle unless a finished sum meets a full queue; sums
// wait for the idle 14-step restoring divider (two sums may queue ahead).
// Reset: rst_n asynchronous, active low; clears the accumulator, queue and
// handshakes, and sets gain to 1.0 and output_layer to 0.
module neuron_dot_product_softsign_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ndps_in_if.sink                             din,
    ndps_out_if.source                          dout,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ndps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ndps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ndps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int S_W = ACC_WIDTH - ndps_pkg::FRAC_BITS;

    ndps_pkg::cfg_t         cfg_reg;
    ndps_pkg::reg_index_t   reg_index;
    logic                   cfg_write;

    logic                   push_valid;
    logic [S_W-1:0]         push_data;
    logic                   queue_full;
    logic                   queue_valid;
    logic [S_W-1:0]         queue_data;
    logic                   pop_ready;

    // Register decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = ndps_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain         <= ndps_pkg::GAIN_RESET;
            cfg_reg.output_layer <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                ndps_pkg::REG_GAIN:         cfg_reg.gain <= pwdata[ndps_pkg::GAIN_W-1:0];
                ndps_pkg::REG_OUTPUT_LAYER: cfg_reg.output_layer <= pwdata[0];
                default:                    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_index)
            ndps_pkg::REG_GAIN:
                prdata = ndps_pkg::APB_DATA_W'(cfg_reg.gain);
            ndps_pkg::REG_OUTPUT_LAYER:
                prdata = ndps_pkg::APB_DATA_W'(cfg_reg.output_layer);
            default:
                prdata = '0;
        endcase
    end

    ndps_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (din.valid),
        .in_ready   (din.ready),
        .activation (din.activation),
        .weight     (din.weight),
        .last       (din.last),
        .push_valid (push_valid),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    ndps_fifo #(
        .WIDTH (S_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop_ready && queue_valid),
        .not_empty (queue_valid),
        .pop_data  (queue_data)
    );

    ndps_back #(
        .S_W (S_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (queue_valid),
        .pop_ready (pop_ready),
        .pop_data  (queue_data),
        .cfg       (cfg_reg),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .result    (dout.result)
    );

endmodule

/* rtl/core/ndps_checker.sv */
module ndps_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ndps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ndps_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [ndps_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [ndps_pkg::RESULT_W-1:0]       result
);

    logic cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed while stalled");

    // Never insert wait states
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    // Gain reads back sign extended
    a_gain_readback: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && !paddr[2] ##1 !paddr[2] |->
            prdata == {{16{$past(pwdata[15])}}, $past(pwdata[15:0])})
        else $error("gain readback mismatch");

    // Output layer flag reads back
    a_layer_readback: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && paddr[2] ##1 paddr[2] |->
            prdata == {31'b0, $past(pwdata[0])})
        else $error("output_layer readback mismatch");

endmodule

bind neuron_dot_product_softsign_unit ndps_checker u_ndps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .result    (dout.result)
);
